@@ sv/kdc_pkg.sv @@
// ----------------------------------------------------------------------------
// kdc_pkg
// Shared types and key codes for the keypad decimal calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package kdc_pkg;

    localparam int unsigned KeyW  = 8;
    localparam int unsigned DataW = 32;
    localparam int unsigned CntW  = $clog2(DataW);

    localparam logic [KeyW-1:0] KEY_NONE   = 8'h00;
    localparam logic [KeyW-1:0] KEY_PLUS   = 8'h2B;
    localparam logic [KeyW-1:0] KEY_MINUS  = 8'h2D;
    localparam logic [KeyW-1:0] KEY_TIMES  = 8'h2A;
    localparam logic [KeyW-1:0] KEY_DIVIDE = 8'h2F;
    localparam logic [KeyW-1:0] KEY_EQUALS = 8'h3D;
    localparam logic [KeyW-1:0] KEY_ZERO   = 8'h30;
    localparam logic [KeyW-1:0] KEY_NINE   = 8'h39;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_SKIP
    } t_phase;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_ZERO
    } t_op;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_DONE
    } t_alu_state;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_status;

    function automatic t_op decode_op(input logic [KeyW-1:0] key);
        t_op op;
        unique case (key)
            KEY_PLUS:   op = OP_ADD;
            KEY_MINUS:  op = OP_SUB;
            KEY_TIMES:  op = OP_MUL;
            KEY_DIVIDE: op = OP_DIV;
            default:    op = OP_ZERO;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

@@ sv/kdc_parser.sv @@
// ----------------------------------------------------------------------------
// kdc_parser
// Key parser: builds both operands one digit per key and latches the operator.
// ----------------------------------------------------------------------------
`default_nettype none

module kdc_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_key_valid,
    input  wire logic [kdc_pkg::KeyW-1:0]    i_key,
    output kdc_pkg::t_alu_req                o_req,
    output logic      [kdc_pkg::DataW-1:0]   o_first,
    output logic      [kdc_pkg::DataW-1:0]   o_second
);
    import kdc_pkg::*;

    t_phase            r_phase,  n_phase;
    t_op               r_op,     n_op;
    logic [DataW-1:0]  r_first,  n_first;
    logic [DataW-1:0]  r_second, n_second;

    logic              key_digit;
    logic [3:0]        digit;
    logic              key_eq;
    logic [DataW-1:0]  acc_src;
    logic [DataW-1:0]  acc_next;

    assign key_digit = (i_key >= KEY_ZERO) && (i_key <= KEY_NINE);
    assign key_eq    = (i_key == KEY_EQUALS);
    assign digit     = 4'(i_key - KEY_ZERO);
    assign acc_src   = (r_phase == PH_FIRST) ? r_first : r_second;
    // x*10 + d as two shifted copies plus the digit
    assign acc_next  = (acc_src << 3) + (acc_src << 1) + DataW'(digit);

    always_comb begin
        n_phase  = r_phase;
        n_op     = r_op;
        n_first  = r_first;
        n_second = r_second;
        o_req    = '{start: 1'b0, op: r_op};
        if (i_key_valid && (i_key != KEY_NONE)) begin
            if (key_eq) begin
                o_req.start = 1'b1;
                if (r_phase == PH_FIRST) begin
                    o_req.op = OP_ZERO;
                end
                n_phase  = PH_FIRST;
                n_op     = OP_ZERO;
                n_first  = '0;
                n_second = '0;
            end else begin
                unique case (r_phase)
                    PH_FIRST: begin
                        if (key_digit) begin
                            n_first = acc_next;
                        end else begin
                            n_op    = decode_op(i_key);
                            n_phase = PH_SECOND;
                        end
                    end
                    PH_SECOND: begin
                        if (key_digit) begin
                            n_second = acc_next;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_op     <= OP_ZERO;
            r_first  <= '0;
            r_second <= '0;
        end else begin
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    assign o_first  = r_first;
    assign o_second = r_second;

endmodule

`default_nettype wire

@@ sv/kdc_alu.sv @@
// ----------------------------------------------------------------------------
// kdc_alu
// Evaluation unit: add and subtract in one step, bit-serial shift-add multiply
// and restoring divide at one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kdc_alu (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire kdc_pkg::t_alu_req           i_req,
    input  wire logic [kdc_pkg::DataW-1:0]   i_a,
    input  wire logic [kdc_pkg::DataW-1:0]   i_b,
    input  wire logic                        i_take,
    output kdc_pkg::t_alu_status             o_status,
    output logic      [kdc_pkg::DataW-1:0]   o_result
);
    import kdc_pkg::*;

    t_alu_state        r_state, n_state;
    logic [CntW-1:0]   r_cnt,   n_cnt;
    logic [DataW-1:0]  r_acc,   n_acc;    // product, remainder, or final result
    logic [DataW-1:0]  r_sa,    n_sa;     // multiplicand / dividend-quotient
    logic [DataW-1:0]  r_sb,    n_sb;     // multiplier / divisor

    logic [DataW:0]    rem_sh;
    logic              rem_ge;

    assign rem_sh = {r_acc, r_sa[DataW-1]};
    assign rem_ge = rem_sh >= {1'b0, r_sb};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == OP_MUL) begin
                        n_state = ALU_MUL;
                    end else if (i_req.op == OP_DIV && i_b != '0) begin
                        n_state = ALU_DIV;
                    end else begin
                        n_state = ALU_DONE;
                    end
                end
            end
            ALU_MUL, ALU_DIV: begin
                if (r_cnt == CntW'(DataW-1)) begin
                    n_state = ALU_DONE;
                end
            end
            ALU_DONE: begin
                if (i_take) begin
                    n_state = ALU_IDLE;
                end
            end
            default: n_state = ALU_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_cnt = r_cnt;
        n_acc = r_acc;
        n_sa  = r_sa;
        n_sb  = r_sb;
        unique case (r_state)
            ALU_IDLE: begin
                n_cnt = '0;
                n_sa  = i_a;
                n_sb  = i_b;
                case (i_req.op)
                    OP_ADD:  n_acc = i_a + i_b;
                    OP_SUB:  n_acc = i_a - i_b;
                    default: n_acc = '0;
                endcase
            end
            ALU_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_sb[0]) begin
                    n_acc = r_acc + r_sa;
                end
                n_sa = r_sa << 1;
                n_sb = r_sb >> 1;
            end
            ALU_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (rem_ge) begin
                    n_acc = DataW'(rem_sh - {1'b0, r_sb});
                end else begin
                    n_acc = DataW'(rem_sh);
                end
                n_sa = {r_sa[DataW-2:0], rem_ge};
                if (r_cnt == CntW'(DataW-1)) begin
                    // quotient lands in the result register
                    n_acc = {r_sa[DataW-2:0], rem_ge};
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ALU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_sa  <= n_sa;
        r_sb  <= n_sb;
    end

    // outputs
    always_comb begin
        o_status.busy = (r_state != ALU_IDLE);
        o_status.done = (r_state == ALU_DONE);
        o_result      = r_acc;
    end

endmodule

`default_nettype wire

@@ sv/keypad_decimal_calculator.sv @@
// ----------------------------------------------------------------------------
// keypad_decimal_calculator
// Four-function decimal calculator fed by ASCII key beats.
// ----------------------------------------------------------------------------
// Evaluation: '+', '-', unknown operator and divide by zero are computed on
//   the '=' beat into the ALU result register and then pass to the output
//   register; '*' and '/' first run the bit-serial multiply/divide loop that
//   retires one bit per cycle.
// Throughput: one key beat per cycle while the evaluation unit is idle;
//   the input stalls after the '=' beat until the result is handed over.
// Reset: synchronous, active low; clears the parser and the output valid.
`default_nettype none

module keypad_decimal_calculator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [kdc_pkg::KeyW-1:0]   s_axis_tdata,   // [7:0] key_code
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic      [kdc_pkg::DataW-1:0]  m_axis_tdata    // [31:0] result_value
);
    import kdc_pkg::*;

    t_alu_req          alu_req;
    t_alu_status       alu_status;
    logic [DataW-1:0]  first_op;
    logic [DataW-1:0]  second_op;
    logic [DataW-1:0]  alu_result;
    logic              in_beat;
    logic              alu_take;

    logic              r_out_valid;
    logic [DataW-1:0]  r_out_data;

    // Take keys only while the evaluation unit is free; a finished result
    // moves to the output register, so keys keep flowing while it waits.
    assign s_axis_tready = !alu_status.busy;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    kdc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_valid (in_beat),
        .i_key       (s_axis_tdata),
        .o_req       (alu_req),
        .o_first     (first_op),
        .o_second    (second_op)
    );

    // Hand the result over once the output register is empty or draining.
    assign alu_take = alu_status.done && (!r_out_valid || m_axis_tready);

    kdc_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (first_op),
        .i_b      (second_op),
        .i_take   (alu_take),
        .o_status (alu_status),
        .o_result (alu_result)
    );

    // Output register: load on hand-over, drop on the downstream beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (alu_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (alu_take) begin
            r_out_data <= alu_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A new evaluation is only requested while the unit is idle.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> !alu_status.busy)
        else $error("evaluation requested while unit busy");

    // A request always occupies the unit on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |=> alu_status.busy)
        else $error("evaluation request lost");

    // A hand-over presents the unit's result on the output.
    a_take_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_take |=> (m_axis_tvalid && m_axis_tdata == $past(alu_result)))
        else $error("result hand-over mismatch");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keypad_decimal_calculator. A directed table walks
// the corner cases, then random expressions with noise keys. Each result
// beat is compared with a typed value or a running prediction of the parser
// and evaluator. Both sides are throttled at random but for a calm stretch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kdc_pkg::*;

    localparam int unsigned RANDOM_KEYS  = 1950;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned STEADY_FROM  = 900;
    localparam int unsigned STEADY_TO    = 1250;
    localparam logic [DataW-1:0] RADIX   = 32'd10;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [KeyW-1:0]    s_axis_tdata = '0;     // [7:0] key_code
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [DataW-1:0]   m_axis_tdata;          // [31:0] result_value

    // Running parser state of the calculator as the bench sees it
    t_phase             calc_phase  = PH_FIRST;
    logic [DataW-1:0]   acc_first   = '0;
    logic [DataW-1:0]   acc_second  = '0;
    logic [KeyW-1:0]    op_key      = KEY_NONE;

    logic [DataW-1:0]   result_q[$];
    int unsigned        keys_sent  = 0;
    int unsigned        fail_count = 0;
    int unsigned        cycle_count = 0;
    bit                 steady_run = 1'b0;

    // One row of the directed table: a key, and a hand-typed result where the
    // answer is obvious (otherwise the prediction is used).
    typedef struct packed {
        logic [KeyW-1:0]  key;
        logic             typed;
        logic [DataW-1:0] value;
    } t_key_row;

    localparam int unsigned DIRECTED_ROWS = 23;

    t_key_row directed_keys [0:DIRECTED_ROWS-1] = '{
        // equals right after reset: '=' becomes the operator, unknown
        '{KEY_EQUALS,      1'b1, 32'd0},
        // divide by zero
        '{KEY_NINE,        1'b0, 32'd0},
        '{KEY_DIVIDE,      1'b0, 32'd0},
        '{KEY_ZERO,        1'b0, 32'd0},
        '{KEY_EQUALS,      1'b1, 32'd0},
        // subtraction wraps below zero
        '{KEY_ZERO + 8'd7, 1'b0, 32'd0},
        '{KEY_MINUS,       1'b0, 32'd0},
        '{KEY_ZERO + 8'd8, 1'b0, 32'd0},
        '{KEY_EQUALS,      1'b1, 32'hFFFF_FFFF},
        // no-key beat mid operand, then a second operator closes operand two
        '{KEY_ZERO + 8'd6, 1'b0, 32'd0},
        '{KEY_NONE,        1'b0, 32'd0},
        '{KEY_TIMES,       1'b0, 32'd0},
        '{KEY_ZERO + 8'd7, 1'b0, 32'd0},
        '{KEY_PLUS,        1'b0, 32'd0},
        '{KEY_ZERO + 8'd5, 1'b0, 32'd0},
        '{KEY_EQUALS,      1'b0, 32'd0},
        // all-ones key as an unknown operator
        '{8'hFF,           1'b0, 32'd0},
        '{KEY_ZERO + 8'd3, 1'b0, 32'd0},
        '{KEY_EQUALS,      1'b1, 32'd0},
        // addition with a high-bit key ending operand two
        '{KEY_NINE,        1'b0, 32'd0},
        '{KEY_PLUS,        1'b0, 32'd0},
        '{8'h80,           1'b0, 32'd0},
        '{KEY_EQUALS,      1'b0, 32'd0}
    };

    keypad_decimal_calculator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the calculator state by one key; flag and return a result on '='.
    function automatic void calc_step(input logic [KeyW-1:0] key, output bit emit,
                                      output logic [DataW-1:0] value);
        bit digit;
        digit = (key >= KEY_ZERO) && (key <= KEY_NINE);
        emit  = 1'b0;
        value = '0;
        if (key == KEY_NONE)
            return;
        if (calc_phase == PH_FIRST) begin
            if (digit) begin
                acc_first = acc_first * RADIX + {24'd0, key - KEY_ZERO};
                return;
            end
            op_key = key;
            if (key != KEY_EQUALS) begin
                calc_phase = PH_SECOND;
                return;
            end
        end else if (key != KEY_EQUALS) begin
            // past operand two every key except '=' is dropped
            if (calc_phase == PH_SECOND) begin
                if (digit)
                    acc_second = acc_second * RADIX + {24'd0, key - KEY_ZERO};
                else
                    calc_phase = PH_SKIP;
            end
            return;
        end
        emit = 1'b1;
        case (op_key)
            KEY_PLUS:   value = acc_first + acc_second;
            KEY_MINUS:  value = acc_first - acc_second;
            KEY_TIMES:  value = acc_first * acc_second;
            KEY_DIVIDE: value = (acc_second != '0) ? acc_first / acc_second : '0;
            default:    value = '0;
        endcase
        calc_phase = PH_FIRST;
        acc_first  = '0;
        acc_second = '0;
        op_key     = KEY_NONE;
    endfunction

    // Drive one key beat, with a random idle run first, and hold it until
    // the calculator takes it.
    task automatic push_key(input logic [KeyW-1:0] key, input bit typed,
                            input logic [DataW-1:0] typed_val);
        bit               emit;
        logic [DataW-1:0] value;
        @(negedge i_clk);
        // keep idling while a random draw falls under 38 in a hundred
        while (!steady_run && $urandom_range(99) < 38) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = key;
        do @(posedge i_clk); while (!s_axis_tready);
        calc_step(key, emit, value);
        if (emit)
            result_q.push_back(typed ? typed_val : value);
        if (key != KEY_NONE)
            keys_sent++;
        steady_run = (keys_sent >= STEADY_FROM) && (keys_sent < STEADY_TO);
    endtask

    // Random key with the occasional no-key beat in front of it
    task automatic feed_key(input logic [KeyW-1:0] key);
        if ($urandom_range(24) == 0)
            push_key(KEY_NONE, 1'b0, '0);
        push_key(key, 1'b0, '0);
    endtask

    // One expression: digits, operator, digits, optional junk, '='.
    // A tenth of the time send a short burst of raw bytes instead.
    task automatic send_expression();
        logic [KeyW-1:0] op_pick;
        int unsigned     digits;
        int unsigned     k;
        if ($urandom_range(9) == 0) begin
            digits = $urandom_range(6, 1);
            for (k = 0; k < digits; k++)
                feed_key(KEY_ZERO + 8'($urandom_range(255)));
            return;
        end
        digits = ($urandom_range(7) == 0) ? $urandom_range(14, 10) : $urandom_range(5, 0);
        for (k = 0; k < digits; k++)
            feed_key(KEY_ZERO + 8'($urandom_range(9)));
        case ($urandom_range(19))
            0, 1:    op_pick = 8'($urandom_range(255));
            2:       op_pick = KEY_EQUALS;
            default: begin
                case ($urandom_range(3))
                    0:       op_pick = KEY_PLUS;
                    1:       op_pick = KEY_MINUS;
                    2:       op_pick = KEY_TIMES;
                    default: op_pick = KEY_DIVIDE;
                endcase
            end
        endcase
        feed_key(op_pick);
        digits = ($urandom_range(7) == 0) ? $urandom_range(14, 10) : $urandom_range(5, 0);
        for (k = 0; k < digits; k++)
            feed_key(KEY_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(6) == 0) begin
            digits = $urandom_range(3, 1);
            for (k = 0; k < digits; k++)
                feed_key(8'($urandom_range(255)));
        end
        feed_key(KEY_EQUALS);
    endtask

    // Result side backpressure; steady during the calm stretch
    always @(negedge i_clk) begin
        m_axis_tready = steady_run || ($urandom_range(99) >= 38);
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $error("result_value: expected none, actual %h", m_axis_tdata);
                fail_count++;
            end else if (m_axis_tdata !== result_q[0]) begin
                $error("result_value: expected %h, actual %h", result_q[0], m_axis_tdata);
                fail_count++;
                void'(result_q.pop_front());
            end else begin
                void'(result_q.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned row;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++)
            push_key(directed_keys[row].key, directed_keys[row].typed,
                     directed_keys[row].value);

        while (keys_sent < RANDOM_KEYS + DIRECTED_ROWS)
            send_expression();

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = KEY_NONE;

        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (result_q.size() != 0) begin
            $error("result_value: %0d expected beats never arrived", result_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
